@@ sv/lzl_pkg.sv @@
// Shared types, constants and helpers for the longest zero line block.
// No dependencies; every other file imports this package.
package lzl_pkg;

  localparam int unsigned RUN_W            = 8;
  localparam int unsigned ROW_LEN_W        = 8;
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 3;
  localparam int unsigned MAX_COLS_DEFAULT = 128;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 8'd128;
  localparam logic [RUN_W-1:0]     RUN_MAX          = 8'hFF;

  // register index, taken from paddr above the byte offset
  localparam logic [0:0] REG_ROW_LENGTH = 1'b0;

  // extend a zero run by one cell, saturating; a nonzero cell breaks the run
  function automatic logic [RUN_W-1:0] grow(input logic [RUN_W-1:0] prior,
                                             input logic is_zero);
    if (!is_zero) begin
      return '0;
    end
    return (prior == RUN_MAX) ? RUN_MAX : prior + RUN_W'(1);
  endfunction

  function automatic logic [RUN_W-1:0] max2(input logic [RUN_W-1:0] a,
                                             input logic [RUN_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ sv/lzl_colmem.sv @@
// Per-column run store: one write port, one read port with registered data.
// Depends on lzl_pkg for default sizes.
module lzl_colmem import lzl_pkg::*; #(
  parameter int unsigned DEPTH = MAX_COLS_DEFAULT,
  parameter int unsigned DW    = RUN_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lzl_apb.sv @@
// APB register slave holding the row length register.
// Depends on lzl_pkg for widths, reset value and register index.
module lzl_apb import lzl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [ROW_LEN_W-1:0]  row_length_o
);

  logic [ROW_LEN_W-1:0] row_length_q;
  logic                 wr_row;

  assign pready = 1'b1;
  assign wr_row = psel && penable && pwrite && (paddr[2] == REG_ROW_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LENGTH_RESET;
    end else if (wr_row) begin
      row_length_q <= pwdata[ROW_LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ROW_LENGTH) begin
      prdata = APB_DATA_W'(row_length_q);
    end
  end

  assign row_length_o = row_length_q;

endmodule

@@ sv/longest_zero_line_in_grid.sv @@
// Longest zero line in a raster-order binary grid: row, column, both diagonals.
// The result of a last cell passes the update stage and out_run_q to longest_run_o.
// Throughput: one cell per cycle while in_stall_o is low; the column memory read is
// registered ahead of the update stage. Reset clears control, run state and the fill
// count; column memories are not swept, the fill count marks which columns hold data.
// row_length resets to 128. Depends on lzl_pkg, lzl_apb and lzl_colmem.
module longest_zero_line_in_grid import lzl_pkg::*; #(
  parameter int unsigned MAX_COLS = MAX_COLS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cell_value_i,
  input  logic                  last_cell_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RUN_W-1:0]      longest_run_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned NW = $clog2(MAX_COLS + 1);
  localparam int unsigned LW = (NW > ROW_LEN_W) ? NW : ROW_LEN_W;

  logic [ROW_LEN_W-1:0] row_length;

  // front: column tracking and read issue
  logic [CW-1:0] col_q, col_d;
  logic [LW-1:0] width, rl_ext, col_ext, c_ext, c1_ext;
  logic [CW-1:0] c_idx, anti_idx;
  logic          anti_en, in_acc, a_ready;

  // update stage
  logic               a_valid_q, a_zero_q, a_last_q, a_cz_q;
  logic [CW-1:0]      a_c_q;
  logic               vd_ok_q, vd_byp_q, an_ok_q, an_byp_q;
  logic [2*RUN_W-1:0] vd_bval_q, vd_rd, vd;
  logic [RUN_W-1:0]   an_bval_q, an_rd, an;
  logic [RUN_W-1:0]   hz_q, held_q, best_q;
  logic [NW-1:0]      fill_q, a_c1;
  logic [RUN_W-1:0]   h_new, v_new, d_new, a_new, best_new;
  logic               a_adv, clr, out_free;

  logic               out_valid_q;
  logic [RUN_W-1:0]   out_run_q;

  lzl_apb u_apb (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .row_length_o (row_length)
  );

  // clamp width to 1..MAX_COLS and the column to the last one in use
  always_comb begin
    rl_ext  = LW'(row_length);
    width   = (rl_ext == '0) ? LW'(1) :
              (rl_ext > LW'(MAX_COLS)) ? LW'(MAX_COLS) : rl_ext;
    col_ext = LW'(col_q);
    c_ext   = (col_ext >= width) ? width - LW'(1) : col_ext;
    c1_ext  = c_ext + LW'(1);
    anti_en = c1_ext < width;
    c_idx   = c_ext[CW-1:0];
    anti_idx = c1_ext[CW-1:0];
    col_d   = (anti_en && !last_cell_i) ? c1_ext[CW-1:0] : '0;
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign a_adv      = a_valid_q && (!a_last_q || out_free);
  assign a_ready    = !a_valid_q || a_adv;
  assign in_stall_o = !a_ready;
  assign in_acc     = in_valid_i && a_ready;
  assign clr        = a_adv && a_last_q;

  lzl_colmem #(.DEPTH(MAX_COLS), .DW(2*RUN_W)) u_vd_mem (
    .clk_i,
    .we_i    (a_adv),
    .waddr_i (a_c_q),
    .wdata_i ({v_new, d_new}),
    .re_i    (in_acc),
    .raddr_i (c_idx),
    .rdata_o (vd_rd)
  );

  lzl_colmem #(.DEPTH(MAX_COLS), .DW(RUN_W)) u_an_mem (
    .clk_i,
    .we_i    (a_adv),
    .waddr_i (a_c_q),
    .wdata_i (a_new),
    .re_i    (in_acc),
    .raddr_i (anti_idx),
    .rdata_o (an_rd)
  );

  always_comb begin
    vd    = vd_byp_q ? vd_bval_q : (vd_ok_q ? vd_rd : '0);
    an    = an_byp_q ? an_bval_q : (an_ok_q ? an_rd : '0);
    h_new = grow(a_cz_q ? '0 : hz_q, a_zero_q);
    v_new = grow(vd[2*RUN_W-1:RUN_W], a_zero_q);
    d_new = grow(a_cz_q ? '0 : held_q, a_zero_q);
    a_new = grow(an, a_zero_q);
    best_new = max2(max2(best_q, h_new), max2(max2(v_new, d_new), a_new));
    a_c1  = NW'(a_c_q) + NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      a_valid_q <= 1'b0;
      hz_q      <= '0;
      held_q    <= '0;
      best_q    <= '0;
      fill_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q <= col_d;
      end
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (a_adv) begin
        if (a_last_q) begin
          hz_q   <= '0;
          held_q <= '0;
          best_q <= '0;
          fill_q <= '0;
        end else begin
          hz_q   <= h_new;
          held_q <= vd[RUN_W-1:0];
          best_q <= best_new;
          fill_q <= (a_c1 > fill_q) ? a_c1 : fill_q;
        end
      end
      if (clr) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // beat payload and read qualifiers; bypass the write landing on this edge
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_zero_q  <= !cell_value_i;
      a_last_q  <= last_cell_i;
      a_c_q     <= c_idx;
      a_cz_q    <= (c_ext == '0);
      vd_ok_q   <= !clr && (c_ext < LW'(fill_q));
      vd_byp_q  <= !clr && a_adv && (a_c_q == c_idx);
      vd_bval_q <= {v_new, d_new};
      an_ok_q   <= !clr && anti_en && (c1_ext < LW'(fill_q));
      an_byp_q  <= !clr && anti_en && a_adv && (LW'(a_c_q) == c1_ext);
      an_bval_q <= a_new;
    end
    if (clr) begin
      out_run_q <= best_new;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign longest_run_o = out_run_q;

  a_col_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q |-> (LW'(a_c_q) <= LW'(fill_q)))
    else $error("update stage column beyond written prefix");

  a_last_clears_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_cell_i) |=> (col_q == '0))
    else $error("column not cleared after final cell");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(a_adv && a_last_q))
    else $error("result without a final cell");

  a_hold_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !a_adv) |-> (a_last_q && out_valid_q && out_stall_i))
    else $error("update stage held without a blocked result");

endmodule
